// ===== rtl/vngc_pkg.sv =====
// shared constants, types and helpers for the value noise gradient compositor
package vngc_pkg;

  // top level parameter defaults
  localparam int COORD_BITS_DEF = 12;
  localparam int MAX_STOPS_DEF  = 8;

  // hash multipliers
  localparam logic [31:0] PRIME_X = 32'd2654435761;
  localparam logic [31:0] PRIME_Y = 32'd2246822519;
  localparam logic [31:0] PRIME_Z = 32'd3266489917;
  localparam logic [31:0] MIX_1   = 32'h85ebca6b;
  localparam logic [31:0] MIX_2   = 32'hc2b2ae35;

  // fixed point constants
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [31:0] OVER_D  = 32'd16711680;

  // divider shape: quotient bits, numerator and divisor widths
  localparam int DIV_STEPS = 8;
  localparam int DIV_NUM_W = 41;
  localparam int DIV_DEN_W = 32;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_NOISE_SCALE,
    CFG_TIME_SPEED,
    CFG_OPACITY,
    CFG_GRAD_COUNT,
    CFG_PAIR_01,
    CFG_PAIR_23,
    CFG_PAIR_45,
    CFG_PAIR_67
  } cfg_idx_t;

  // control and the alpha result that travel alongside the divider lanes
  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [7:0] alpha;
  } pipe_ctrl_t;

  // q16 linear blend, result never exceeds the larger end point
  function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                         input logic [16:0] s);
    logic [33:0] sum;
    sum = 34'(a) * 34'(ONE_Q16 - s) + 34'(b) * 34'(s);
    return sum[31:16];
  endfunction

endpackage

// ===== rtl/value_noise_gradient_composite.sv =====
// top level: noise, gradient lookup and over compositing pipeline
// A pixel is taken in every clock cycle (busy never rises) and its composited
// result appears on the out_ ports, marked by out_valid for one cycle, once it
// has passed through 12 stages for position, hash, smoothstep, trilinear blend,
// gradient and over terms, 8 stages of the bit-per-stage dividers, and the
// output register. Results leave in order and cannot be held off by the
// receiver. The configuration registers are read as a pixel moves through
// several stages, so write them with cfg_we only while no pixel is in flight.
module value_noise_gradient_composite import vngc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_STOPS  = MAX_STOPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] in_pixel_x,
  input  logic [COORD_BITS-1:0] in_pixel_y,
  input  logic [9:0]            in_frame_index,
  input  logic [7:0]            in_bg_red,
  input  logic [7:0]            in_bg_green,
  input  logic [7:0]            in_bg_blue,
  input  logic [7:0]            in_bg_alpha,
  output logic                  out_valid,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [63:0]           cfg_wdata
);

  localparam int PX_W   = COORD_BITS + 24;
  localparam int CELL_W = COORD_BITS + 8;
  localparam int NSTG   = 12;

  // configuration registers
  logic [23:0] noise_scale_r, time_speed_r;
  logic [16:0] opacity_r;
  logic [3:0]  grad_count_r;
  logic [63:0] pair_r [4];

  // stage valids and background carry
  logic [NSTG-1:0] vld_r;
  logic [31:0]     bg_r [11];
  logic            accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: positions
  logic [PX_W-1:0] px_r, py_r;
  logic [33:0]     pz_r;

  // stage 2: prime terms, smoothstep squares
  logic [31:0] tx_r [2], ty_r [2], tz_r [2];
  logic [15:0] f_r [3], f2_r [3];
  logic [18:0] six_r [3];

  // stage 3/4: smoothstep
  logic [15:0] f3_r [3];
  logic [20:0] q_r [3];
  logic [16:0] s_r [3];
  logic [16:0] sy5_r, sz5_r, sz6_r;

  // stage 5..7: trilinear blend
  logic [15:0] hv [8];
  logic [15:0] a_r [4];
  logic [15:0] b_r [2];
  logic [15:0] v_r;

  // stage 8..12: gradient and over terms
  logic [2:0]  gi_r;
  logic [3:0]  n8_r;
  logic [16:0] gt_r;
  logic [31:0] ca_r, cb_r;
  logic [7:0]  src9_r [4];
  logic [7:0]  src10_r [3];
  logic [24:0] sn_r, sn11_r;
  logic [31:0] rest_r;
  logic [32:0] pc_r [3];
  logic [31:0] acc_r;
  logic [40:0] num_r [3];

  // divider control and result
  pipe_ctrl_t  ctrl_r [DIV_STEPS];
  logic [7:0]  quo [3];

  // combinational helpers for the datapath
  logic [CELL_W-1:0] x0, y0;
  logic [17:0]       z0;
  logic [15:0]       fin [3];
  logic [31:0]       ff [3];
  logic [34:0]       ff6 [3];
  logic [31:0]       f3p [3];
  logic [36:0]       sp [3];
  logic [3:0]        n;
  logic [18:0]       g;
  logic [2:0]        gi;
  logic [18:0]       gt;
  logic [16:0]       op;
  logic [23:0]       dms;
  logic [32:0]       acc_w;
  logic [15:0]       asum;
  logic [7:0]        alpha_w;

  // configuration and valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_scale_r <= 24'd6554;
      time_speed_r  <= 24'd65536;
      opacity_r     <= ONE_Q16;
      grad_count_r  <= 4'd2;
      for (int k = 0; k < 4; k++) pair_r[k] <= '0;
      vld_r         <= '0;
      for (int k = 0; k < DIV_STEPS; k++) ctrl_r[k] <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index)) inside
          CFG_NOISE_SCALE: noise_scale_r <= cfg_wdata[23:0];
          CFG_TIME_SPEED:  time_speed_r  <= cfg_wdata[23:0];
          CFG_OPACITY:     opacity_r     <= cfg_wdata[16:0];
          CFG_GRAD_COUNT:  grad_count_r  <= cfg_wdata[3:0];
          CFG_PAIR_01, CFG_PAIR_23, CFG_PAIR_45, CFG_PAIR_67:
            pair_r[cfg_index[1:0]] <= cfg_wdata;
          default: ;
        endcase
      end
      vld_r     <= {vld_r[NSTG-2:0], accept};
      ctrl_r[0] <= '{valid: vld_r[NSTG-1], zero: (acc_r == 32'd0), alpha: alpha_w};
      for (int k = 1; k < DIV_STEPS; k++) ctrl_r[k] <= ctrl_r[k-1];
      out_valid <= ctrl_r[DIV_STEPS-1].valid;
    end
  end

  always_comb begin
    x0 = px_r[PX_W-1:16];
    y0 = py_r[PX_W-1:16];
    z0 = pz_r[33:16];
    // fractions straight from the position registers
    fin[0] = px_r[15:0];
    fin[1] = py_r[15:0];
    fin[2] = pz_r[15:0];
    for (int k = 0; k < 3; k++) begin
      ff[k]  = 32'(fin[k]) * 32'(fin[k]);
      ff6[k] = (35'(ff[k]) << 2) + (35'(ff[k]) << 1);
      f3p[k] = 32'(f2_r[k]) * 32'(f_r[k]);
      sp[k]  = 37'(f3_r[k]) * 37'(q_r[k]);
    end
    // stop count clamp and gradient position
    if (grad_count_r < 4'd2) n = 4'd2;
    else if (grad_count_r > 4'(MAX_STOPS)) n = 4'(MAX_STOPS);
    else n = grad_count_r;
    g  = 19'(v_r) * 19'(n - 4'd1);
    gi = (19'(g[18:16]) > 19'(n - 4'd2)) ? 3'(n - 4'd2) : g[18:16];
    gt = g - (19'(gi) << 16);
    op = (opacity_r > ONE_Q16) ? ONE_Q16 : opacity_r;
    dms   = 24'(OVER_D - 32'(sn_r));
    acc_w = (33'(sn11_r) << 8) - 33'(sn11_r) + 33'(rest_r);
    // alpha is coverage over 255 * 2^16: drop the low half, divide by 255
    asum    = acc_r[31:16] + 16'd1 + 16'(acc_r[31:24]);
    alpha_w = asum[15:8];
  end

  function automatic logic [31:0] stop_word(input logic [63:0] pr [4], input logic [2:0] idx);
    logic [63:0] p;
    p = pr[idx[2:1]];
    return idx[0] ? p[63:32] : p[31:0];
  endfunction

  // datapath stages
  always_ff @(posedge clk) begin
    // stage 1
    px_r     <= PX_W'(in_pixel_x) * PX_W'(noise_scale_r);
    py_r     <= PX_W'(in_pixel_y) * PX_W'(noise_scale_r);
    pz_r     <= 34'(in_frame_index) * 34'(time_speed_r);
    bg_r[0]  <= {in_bg_alpha, in_bg_blue, in_bg_green, in_bg_red};
    for (int k = 1; k < 11; k++) bg_r[k] <= bg_r[k-1];
    // stage 2
    tx_r[0] <= 32'(32'(x0) * PRIME_X);
    tx_r[1] <= 32'(32'(x0 + CELL_W'(1)) * PRIME_X);
    ty_r[0] <= 32'(32'(y0) * PRIME_Y);
    ty_r[1] <= 32'(32'(y0 + CELL_W'(1)) * PRIME_Y);
    tz_r[0] <= 32'(32'(z0) * PRIME_Z);
    tz_r[1] <= 32'(32'(z0 + 18'd1) * PRIME_Z);
    f_r[0]  <= px_r[15:0];
    f_r[1]  <= py_r[15:0];
    f_r[2]  <= pz_r[15:0];
    for (int k = 0; k < 3; k++) begin
      f2_r[k]  <= ff[k][31:16];
      six_r[k] <= ff6[k][34:16];
      // stage 3
      f3_r[k]  <= f3p[k][31:16];
      q_r[k]   <= 21'd655360 + 21'(six_r[k]) - 21'(f_r[k]) * 21'd15;
      // stage 4
      s_r[k]   <= sp[k][32:16];
    end
    // stage 5: blend along x
    a_r[0] <= lerp16(hv[0], hv[1], s_r[0]);
    a_r[1] <= lerp16(hv[2], hv[3], s_r[0]);
    a_r[2] <= lerp16(hv[4], hv[5], s_r[0]);
    a_r[3] <= lerp16(hv[6], hv[7], s_r[0]);
    sy5_r  <= s_r[1];
    sz5_r  <= s_r[2];
    // stage 6: along y
    b_r[0] <= lerp16(a_r[0], a_r[1], sy5_r);
    b_r[1] <= lerp16(a_r[2], a_r[3], sy5_r);
    sz6_r  <= sz5_r;
    // stage 7: along time
    v_r    <= lerp16(b_r[0], b_r[1], sz6_r);
    // stage 8: gradient segment
    gi_r   <= gi;
    n8_r   <= n;
    gt_r   <= 17'(gt);
    ca_r   <= stop_word(pair_r, gi);
    cb_r   <= stop_word(pair_r, gi + 3'd1);
    // stage 9: noise colour
    for (int c = 0; c < 4; c++) begin
      src9_r[c] <= 8'(lerp16(16'(ca_r[8*c +: 8]), 16'(cb_r[8*c +: 8]), gt_r));
    end
    // stage 10: source coverage
    sn_r <= 25'(src9_r[3]) * 25'(op);
    for (int c = 0; c < 3; c++) src10_r[c] <= src9_r[c];
    // stage 11: background weight and source products
    rest_r <= 32'(bg_r[9][31:24]) * 32'(dms);
    sn11_r <= sn_r;
    for (int c = 0; c < 3; c++) pc_r[c] <= 33'(src10_r[c]) * 33'(sn_r);
    // stage 12: coverage and channel numerators
    acc_r <= 32'(acc_w);
    for (int c = 0; c < 3; c++) begin
      num_r[c] <= (41'(pc_r[c]) << 8) - 41'(pc_r[c])
                + 41'(bg_r[10][8*c +: 8]) * 41'(rest_r);
    end
    // output register, zero coverage forces a blank pixel
    out_red   <= ctrl_r[DIV_STEPS-1].zero ? 8'd0 : quo[0];
    out_green <= ctrl_r[DIV_STEPS-1].zero ? 8'd0 : quo[1];
    out_blue  <= ctrl_r[DIV_STEPS-1].zero ? 8'd0 : quo[2];
    out_alpha <= ctrl_r[DIV_STEPS-1].zero ? 8'd0 : ctrl_r[DIV_STEPS-1].alpha;
  end

  // eight corner hashes, corner bit 0 picks x, bit 1 y, bit 2 time
  for (genvar c = 0; c < 8; c++) begin : g_corner
    vngc_hash u_hash (
      .clk    (clk),
      .term_x (tx_r[c % 2]),
      .term_y (ty_r[(c / 2) % 2]),
      .term_z (tz_r[c / 4]),
      .value  (hv[c])
    );
  end

  // colour lanes divide by coverage
  for (genvar c = 0; c < 3; c++) begin : g_chan
    vngc_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W), .Q_W(DIV_STEPS)) u_div (
      .clk (clk),
      .num (num_r[c]),
      .den (acc_r),
      .quo (quo[c])
    );
  end

  // divider control lines up with the stage that fed it
  a_ctrl_align: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r[DIV_STEPS-1].valid |-> $past(vld_r[NSTG-1], DIV_STEPS))
    else $error("divider control out of step with pipeline");

  // coverage never exceeds full scale, so quotients fit eight bits
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-1] |-> (acc_r <= 32'd4261478400))
    else $error("coverage above full scale");

  // gradient segment stays within the stops in use
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[7] |-> (4'(gi_r) <= n8_r - 4'd2))
    else $error("gradient segment beyond last stop");

endmodule

// ===== rtl/vngc_hash.sv =====
// two stage corner hash finaliser, one multiplier per stage
module vngc_hash import vngc_pkg::*; (
  input  logic        clk,
  input  logic [31:0] term_x,
  input  logic [31:0] term_y,
  input  logic [31:0] term_z,
  output logic [15:0] value
);

  logic [31:0] ha_r, ha_nxt;
  logic [31:0] hb_r, hb_nxt;
  logic [31:0] h0, h1, h2;

  // fold the prime terms, first and second mix multiplies
  always_comb begin
    h0     = term_x ^ term_y ^ term_z;
    h1     = h0 ^ (h0 >> 16);
    ha_nxt = 32'(h1 * MIX_1);
    h2     = ha_r ^ (ha_r >> 13);
    hb_nxt = 32'(h2 * MIX_2);
  end

  always_ff @(posedge clk) begin
    ha_r <= ha_nxt;
    hb_r <= hb_nxt;
  end

  // the last xor-shift leaves the top half unchanged
  assign value = hb_r[31:16];

endmodule

// ===== rtl/vngc_div.sv =====
// restoring divider, one quotient bit per register stage
module vngc_div import vngc_pkg::*; #(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W,
  parameter int Q_W   = DIV_STEPS
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  logic [NUM_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    localparam int SH = Q_W - 1 - i;
    logic [NUM_W-1:0] rem_in, rem_nxt;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in, q_nxt;
    logic [NUM_W:0]   dsh;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
    end

    // trial subtract of the shifted divisor
    always_comb begin
      dsh     = (NUM_W+1)'(den_in) << SH;
      ge      = {1'b0, rem_in} >= dsh;
      rem_nxt = ge ? NUM_W'({1'b0, rem_in} - dsh) : rem_in;
      q_nxt   = q_in | (Q_W'(ge) << SH);
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= rem_nxt;
      den_r[i] <= den_in;
      q_r[i]   <= q_nxt;
    end
  end

  assign quo = q_r[Q_W-1];

endmodule

// ===== bench/value_noise_gradient_composite_test.sv =====
// self-checking bench for the value noise gradient compositor
module value_noise_gradient_composite_test import vngc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [9:0]  frame;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
  } pixel_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [11:0] in_pixel_x = '0;
  logic [11:0] in_pixel_y = '0;
  logic [9:0]  in_frame_index = '0;
  logic [7:0]  in_bg_red = '0;
  logic [7:0]  in_bg_green = '0;
  logic [7:0]  in_bg_blue = '0;
  logic [7:0]  in_bg_alpha = '0;
  logic        out_valid;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  // register copies used by the predictor
  logic [23:0] scale_q16 = 24'd6554;
  logic [23:0] speed_q16 = 24'd65536;
  logic [16:0] opacity_q16 = 17'd65536;
  logic [3:0]  stop_count = 4'd2;
  logic [63:0] stop_pairs [4] = '{default: '0};

  rgba_t  expected_pixels [$];
  rgba_t  typed_pixels [$];
  bit     use_typed = 1'b0;
  int     mismatches = 0;
  int     items_sent = 0;
  int     pixels_checked = 0;
  int     idle_pct = 0;

  value_noise_gradient_composite dut (
    .clk, .rst_n, .start, .busy,
    .in_pixel_x, .in_pixel_y, .in_frame_index,
    .in_bg_red, .in_bg_green, .in_bg_blue, .in_bg_alpha,
    .out_valid, .out_red, .out_green, .out_blue, .out_alpha,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // safety net against a hung run
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // corner value of the lattice hash, top 16 bits
  function automatic logic [15:0] lattice_value(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic [31:0] h;
    h = (x * PRIME_X) ^ (y * PRIME_Y) ^ (z * PRIME_Z);
    h = h ^ (h >> 16);
    h = h * MIX_1;
    h = h ^ (h >> 13);
    h = h * MIX_2;
    h = h ^ (h >> 16);
    return h[31:16];
  endfunction

  // quintic fade of a q16 fraction
  function automatic longint unsigned fade_q16(longint unsigned f);
    longint unsigned f2, f3, q;
    f2 = (f * f) >> 16;
    f3 = (f2 * f) >> 16;
    q = 655360 + ((6 * f * f) >> 16) - 15 * f;
    return (f3 * q) >> 16;
  endfunction

  function automatic longint unsigned blend_q16(longint unsigned a, longint unsigned b,
                                                longint unsigned s);
    return (a * (65536 - s) + b * s) >> 16;
  endfunction

  function automatic logic [31:0] stop_colour(int idx);
    logic [63:0] pair;
    pair = stop_pairs[(idx >> 1) & 3];
    return (idx & 1) ? pair[63:32] : pair[31:0];
  endfunction

  // full noise, gradient and over computation for one pixel
  function automatic rgba_t composite_pixel(pixel_t p);
    longint unsigned px, py, pz, sx, sy, sz, a00, a10, a01, a11, b0, b1, v;
    longint unsigned n, g, gi, gt, op, sn, rest, acc, q;
    longint unsigned src [4];
    longint unsigned bgc [4];
    logic [31:0] x0, y0, z0, ca, cb;
    rgba_t res;
    px = longint'(p.x) * scale_q16;
    py = longint'(p.y) * scale_q16;
    pz = longint'(p.frame) * speed_q16;
    x0 = px[47:16];
    y0 = py[47:16];
    z0 = pz[47:16];
    sx = fade_q16(px & 16'hFFFF);
    sy = fade_q16(py & 16'hFFFF);
    sz = fade_q16(pz & 16'hFFFF);
    a00 = blend_q16(lattice_value(x0, y0, z0), lattice_value(x0 + 1, y0, z0), sx);
    a10 = blend_q16(lattice_value(x0, y0 + 1, z0), lattice_value(x0 + 1, y0 + 1, z0), sx);
    a01 = blend_q16(lattice_value(x0, y0, z0 + 1), lattice_value(x0 + 1, y0, z0 + 1), sx);
    a11 = blend_q16(lattice_value(x0, y0 + 1, z0 + 1),
                    lattice_value(x0 + 1, y0 + 1, z0 + 1), sx);
    b0 = blend_q16(a00, a10, sy);
    b1 = blend_q16(a01, a11, sy);
    v = blend_q16(b0, b1, sz);
    if (v > 65536) v = 65536;
    // gradient stop lookup with clamped stop count
    n = stop_count;
    if (n < 2) n = 2;
    if (n > 8) n = 8;
    g = v * (n - 1);
    gi = g >> 16;
    if (gi > n - 2) gi = n - 2;
    gt = g - gi * 65536;
    ca = stop_colour(int'(gi));
    cb = stop_colour(int'(gi) + 1);
    for (int c = 0; c < 4; c++) begin
      src[c] = blend_q16((ca >> (8 * c)) & 8'hFF, (cb >> (8 * c)) & 8'hFF, gt);
    end
    bgc[0] = p.r;
    bgc[1] = p.g;
    bgc[2] = p.b;
    bgc[3] = p.a;
    // porter-duff over
    op = (opacity_q16 > 65536) ? 65536 : opacity_q16;
    sn = src[3] * op;
    rest = bgc[3] * (longint'(OVER_D) - sn);
    acc = sn * 255 + rest;
    if (acc == 0) return '0;
    q = (src[0] * sn * 255 + bgc[0] * rest) / acc;
    res.r = (q > 255) ? 8'hFF : q[7:0];
    q = (src[1] * sn * 255 + bgc[1] * rest) / acc;
    res.g = (q > 255) ? 8'hFF : q[7:0];
    q = (src[2] * sn * 255 + bgc[2] * rest) / acc;
    res.b = (q > 255) ? 8'hFF : q[7:0];
    q = acc / OVER_D;
    res.a = (q > 255) ? 8'hFF : q[7:0];
    return res;
  endfunction

  // accepted items and register writes, seen as the block sees them
  always @(posedge clk) begin
    rgba_t next_pixel;
    if (rst_n) begin
      if (start && !busy) begin
        if (use_typed) next_pixel = typed_pixels.pop_front();
        else next_pixel = composite_pixel({in_pixel_x, in_pixel_y,
          in_frame_index, in_bg_red, in_bg_green, in_bg_blue, in_bg_alpha});
        expected_pixels = {expected_pixels, next_pixel};
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NOISE_SCALE: scale_q16 <= cfg_wdata[23:0];
          CFG_TIME_SPEED:  speed_q16 <= cfg_wdata[23:0];
          CFG_OPACITY:     opacity_q16 <= cfg_wdata[16:0];
          CFG_GRAD_COUNT:  stop_count <= cfg_wdata[3:0];
          CFG_PAIR_01:     stop_pairs[0] <= cfg_wdata;
          CFG_PAIR_23:     stop_pairs[1] <= cfg_wdata;
          CFG_PAIR_45:     stop_pairs[2] <= cfg_wdata;
          CFG_PAIR_67:     stop_pairs[3] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    rgba_t got, want;
    if (rst_n && out_valid) begin
      got = {out_red, out_green, out_blue, out_alpha};
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %h", got);
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected r%0d g%0d b%0d a%0d, got r%0d g%0d b%0d a%0d",
                     want.r, want.g, want.b, want.a, got.r, got.g, got.b, got.a);
        end
      end
    end
  end

  // offer one item, honouring the idle rate
  task automatic send_pixel(pixel_t p);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    {in_pixel_x, in_pixel_y, in_frame_index, in_bg_red, in_bg_green, in_bg_blue,
     in_bg_alpha} <= p;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic drain_results();
    int guard;
    start <= 1'b0;
    guard = 0;
    while (expected_pixels.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (25) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    p = 70'({$urandom, $urandom, $urandom});
    if ($urandom_range(1)) begin
      p.x = $urandom_range(63);
      p.y = $urandom_range(63);
    end
    if ($urandom_range(7) == 0) p.a = 8'd0;
    else if ($urandom_range(7) == 0) p.a = 8'hFF;
    return p;
  endfunction

  initial begin
    pixel_t directed_rows [12];
    logic [63:0] regs [8];
    logic [63:0] alpha_mask;
    directed_rows = '{
      '{12'd0, 12'd0, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{12'd0, 12'd0, 10'd0, 8'd255, 8'd255, 8'd255, 8'd255},
      '{12'd4095, 12'd4095, 10'd1023, 8'd255, 8'd255, 8'd255, 8'd255},
      '{12'd4095, 12'd0, 10'd1023, 8'd1, 8'd2, 8'd3, 8'd4},
      '{12'd0, 12'd4095, 10'd0, 8'd128, 8'd64, 8'd32, 8'd1},
      '{12'd2730, 12'd1365, 10'd682, 8'd170, 8'd85, 8'd170, 8'd85},
      '{12'd1365, 12'd2730, 10'd341, 8'd85, 8'd170, 8'd85, 8'd170},
      '{12'd4095, 12'd4095, 10'd1023, 8'd200, 8'd100, 8'd50, 8'd0},
      '{12'd10, 12'd20, 10'd30, 8'd255, 8'd0, 8'd255, 8'd128},
      '{12'd1, 12'd1, 10'd1, 8'd0, 8'd255, 8'd0, 8'd255},
      '{12'd2048, 12'd2048, 10'd512, 8'd12, 8'd34, 8'd56, 8'd78},
      '{12'd4094, 12'd1, 10'd1022, 8'd255, 8'd255, 8'd255, 8'd0}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset stops are transparent, so the background comes through unchanged
    use_typed = 1'b1;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].a == 0) typed_pixels = {typed_pixels, rgba_t'(32'd0)};
      else typed_pixels = {typed_pixels, rgba_t'({directed_rows[i].r, directed_rows[i].g,
                                                  directed_rows[i].b, directed_rows[i].a})};
    end
    foreach (directed_rows[i]) send_pixel(directed_rows[i]);
    drain_results();
    use_typed = 1'b0;

    // register settings, extremes included, each followed by random items
    for (int phase = 0; phase < 8; phase++) begin
      idle_pct = (phase < 3) ? 16 : (phase < 6) ? 48 : 0;
      for (int k = 4; k < 8; k++) regs[k] = {$urandom, $urandom};
      regs[0] = {40'd0, 24'($urandom)};
      regs[1] = {40'd0, 24'($urandom)};
      regs[2] = $urandom_range(65536);
      regs[3] = $urandom_range(2, 8);
      case (phase)
        0: begin
          regs[0] = 6554;
          regs[1] = 65536;
          regs[2] = 65536;
        end
        1: begin
          regs[0] = 0;
          regs[1] = 0;
          regs[2] = 0;
          regs[3] = 8;
        end
        2: begin
          regs[0] = 24'hFFFFFF;
          regs[1] = 24'hFFFFFF;
          regs[2] = 17'h1FFFF;
          regs[3] = 15;
        end
        3: regs[3] = 0;
        4: begin
          // transparent stops give zero coverage over transparent background
          alpha_mask = 64'h00FFFFFF_00FFFFFF;
          for (int k = 4; k < 8; k++) regs[k] = regs[k] & alpha_mask;
          regs[2] = 65536;
        end
        5: regs[3] = 1;
        6: regs[2] = 17'd65537 + $urandom_range(65534);
        default: regs[3] = 9 + $urandom_range(6);
      endcase
      for (int k = 0; k < 8; k++) write_reg(cfg_idx_t'(k), regs[k]);
      cfg_we <= 1'b0;
      @(posedge clk);
      for (int n = 0; n < 192; n++) send_pixel(random_pixel());
      drain_results();
    end

    if (expected_pixels.size() != 0) begin
      mismatches += expected_pixels.size();
      $display("%0d expected pixels never arrived", expected_pixels.size());
    end
    $display("sent %0d pixels over 8 register settings, %0d results compared, %0d mismatches",
             items_sent, pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
